>>> rtl/next_fit_bitmap_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
// Included by files that carry concurrent assertions; needs nothing else.
`ifndef NEXT_FIT_BITMAP_ALLOCATOR_DEFINES_SVH
`define NEXT_FIT_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NFBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NFBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/nfba_pkg.sv
// Shared types, codes and helpers of the next-fit bitmap allocator.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package nfba_pkg;

    localparam int unsigned MAX_BLOCKS_DEF = 4096;
    localparam int unsigned WORD_W         = 32;
    localparam int unsigned WORD_B         = 5;
    localparam int unsigned CNT_W          = 13;
    localparam int unsigned IDX_W          = 12;
    localparam int unsigned OPC_W          = 2;
    localparam int unsigned STS_W          = 2;

    localparam logic [CNT_W-1:0] TOTAL_RST = 13'd4096;

    localparam logic [OPC_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OPC_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OPC_W-1:0] OP_MARK  = 2'd2;

    localparam logic [STS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STS_W-1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic [IDX_W-1:0] block_index;
    } t_in_req;

    typedef struct packed {
        logic [IDX_W-1:0] allocated_block;
        logic [STS_W-1:0] status;
        logic [CNT_W-1:0] free_count;
    } t_out_rsp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW,
        S_SCAN,
        S_RESP
    } t_state;

    // Index of the single set bit of a one-hot map word.
    function automatic logic [WORD_B-1:0] onehot_index(input logic [WORD_W-1:0] oh);
        logic [WORD_B-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (oh[i]) begin
                idx = idx | WORD_B'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> rtl/nfba_map_mem.sv
// Used-bit map storage: one write port, one registered read port.
// Depends on nfba_pkg for the word width.
`default_nettype none

module nfba_map_mem
    import nfba_pkg::*;
#(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [WORD_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/nfba_ctrl.sv
// Sequencer of the allocator: clear pass, read-modify-write of map words,
// word-per-cycle next-fit scan, cursor and used count. Uses nfba_pkg.
`default_nettype none
`include "next_fit_bitmap_allocator_defines.svh"

module nfba_ctrl
    import nfba_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [CNT_W-1:0]  i_size_lim,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_req           i_in_req,
    output logic                   o_rsp_valid,
    output t_out_rsp               o_rsp,
    input  wire logic              i_out_ready,
    output logic [$clog2(((MAX_BLOCKS + WORD_W - 1) / WORD_W > 1) ?
                         (MAX_BLOCKS + WORD_W - 1) / WORD_W : 2)-1:0] o_mem_raddr,
    input  wire logic [WORD_W-1:0] i_mem_rdata,
    output logic                   o_mem_we,
    output logic [$clog2(((MAX_BLOCKS + WORD_W - 1) / WORD_W > 1) ?
                         (MAX_BLOCKS + WORD_W - 1) / WORD_W : 2)-1:0] o_mem_waddr,
    output logic [WORD_W-1:0]      o_mem_wdata
);

    localparam int unsigned NWORDS    = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int unsigned MEM_DEPTH = (NWORDS > 1) ? NWORDS : 2;
    localparam int unsigned WA_W      = $clog2(MEM_DEPTH);
    localparam int unsigned MB_W      = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned PW        = (MB_W > CNT_W) ? MB_W : CNT_W;

    localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_cursor, n_cursor;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [OPC_W-1:0]  r_op, n_op;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [WA_W-1:0]   r_eval_word, n_eval_word;
    logic              r_wrapped, n_wrapped;
    logic [PW-1:0]     r_start, n_start;
    logic [WA_W-1:0]   r_clr_addr, n_clr_addr;
    t_out_rsp          r_res, n_res;

    logic              accept;
    logic [PW-1:0]     total_ext, max_ext, t_eff, t_m1, cur_ext, start_pos, idx_in_ext, idx_ext;
    logic [WA_W-1:0]   last_w, start_w, next_w;
    logic [WORD_B-1:0] last_off, start_off, hit_bit;
    logic [PW-1:0]     free_now_w, free_next_w;
    logic [WORD_W-1:0] lomask, tmask, pmask, cand, onehot, bit_sel;
    logic              scan_hit, at_last, cur_bit, in_range, rmw_ok;
    logic [PW-1:0]     hit_pos;

    assign accept = i_in_valid && !o_in_stall;

    // Managed block count, clamped to the storage size.
    assign total_ext = PW'(i_size_lim);
    assign max_ext   = PW'(MAX_BLOCKS);
    assign t_eff     = (total_ext < max_ext) ? total_ext : max_ext;
    assign t_m1      = t_eff - PW'(1);
    assign last_w    = t_m1[WORD_B +: WA_W];
    assign last_off  = t_m1[WORD_B-1:0];

    assign cur_ext    = PW'(r_cursor);
    assign start_pos  = (cur_ext < t_eff) ? cur_ext : '0;
    assign idx_in_ext = PW'(i_in_req.block_index);
    assign idx_ext    = PW'(r_idx);

    assign free_now_w  = (t_eff > PW'(r_used)) ? t_eff - PW'(r_used) : '0;
    assign free_next_w = (t_eff > PW'(n_used)) ? t_eff - PW'(n_used) : '0;

    // Scan masks: the first pass covers positions from the start onward,
    // the wrapped pass covers positions below the start.
    assign start_w   = r_start[WORD_B +: WA_W];
    assign start_off = r_start[WORD_B-1:0];
    assign lomask    = ONES << start_off;
    assign tmask     = (r_eval_word == last_w) ? (ONES >> (WORD_B'(WORD_W - 1) - last_off))
                                               : ONES;
    assign pmask     = (r_eval_word != start_w) ? ONES : (r_wrapped ? ~lomask : lomask);
    assign cand      = ~i_mem_rdata & tmask & pmask;
    assign onehot    = cand & (~cand + WORD_W'(1));
    assign hit_bit   = onehot_index(onehot);
    assign scan_hit  = |cand;
    assign hit_pos   = (PW'(r_eval_word) << WORD_B) | PW'(hit_bit);
    assign at_last   = (r_eval_word == last_w);
    assign next_w    = at_last ? '0 : r_eval_word + WA_W'(1);

    // Free and mark check the addressed bit.
    assign bit_sel  = WORD_W'(1) << r_idx[WORD_B-1:0];
    assign cur_bit  = |(i_mem_rdata & bit_sel);
    assign in_range = idx_ext < t_eff;
    assign rmw_ok   = in_range && ((r_op == OP_FREE) ? cur_bit : !cur_bit);

    always_comb begin
        n_used = r_used;
        if (r_state == S_SCAN && scan_hit) begin
            n_used = r_used + CNT_W'(1);
        end else if (r_state == S_RMW && rmw_ok) begin
            if (r_op == OP_MARK) begin
                n_used = r_used + CNT_W'(1);
            end else if (r_used != '0) begin
                n_used = r_used - CNT_W'(1);
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == WA_W'(MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_in_req.opcode)
                        OP_ALLOC: begin
                            n_state = (free_now_w == '0) ? S_RESP : S_SCAN;
                        end
                        OP_FREE, OP_MARK: begin
                            n_state = S_RMW;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_RMW: begin
                n_state = S_RESP;
            end
            S_SCAN: begin
                if (scan_hit || (r_wrapped && r_eval_word == start_w)) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_rsp_valid = (r_state == S_RESP);
        o_rsp       = r_res;
        o_mem_raddr = '0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_eval_word;
        o_mem_wdata = i_mem_rdata;
        n_cursor    = r_cursor;
        n_op        = r_op;
        n_idx       = r_idx;
        n_eval_word = r_eval_word;
        n_wrapped   = r_wrapped;
        n_start     = r_start;
        n_clr_addr  = r_clr_addr;
        n_res       = r_res;
        case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr_addr;
                o_mem_wdata = '0;
                n_clr_addr  = r_clr_addr + WA_W'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_in_req.opcode)
                        OP_ALLOC: begin
                            o_mem_raddr = start_pos[WORD_B +: WA_W];
                            n_eval_word = start_pos[WORD_B +: WA_W];
                            n_start     = start_pos;
                            n_wrapped   = 1'b0;
                            n_res       = '{allocated_block: '0, status: ST_FULL,
                                            free_count: free_now_w[CNT_W-1:0]};
                        end
                        OP_FREE, OP_MARK: begin
                            o_mem_raddr = idx_in_ext[WORD_B +: WA_W];
                            n_op        = i_in_req.opcode;
                            n_idx       = i_in_req.block_index;
                        end
                        default: begin
                            n_res = '{allocated_block: '0, status: ST_BAD,
                                      free_count: free_now_w[CNT_W-1:0]};
                        end
                    endcase
                end
            end
            S_RMW: begin
                o_mem_waddr = idx_ext[WORD_B +: WA_W];
                o_mem_wdata = i_mem_rdata ^ bit_sel;
                o_mem_we    = rmw_ok;
                n_res       = '{allocated_block: '0, status: rmw_ok ? ST_OK : ST_BAD,
                                free_count: free_next_w[CNT_W-1:0]};
            end
            S_SCAN: begin
                if (scan_hit) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = i_mem_rdata | onehot;
                    n_cursor    = hit_pos[IDX_W-1:0];
                    n_res       = '{allocated_block: hit_pos[IDX_W-1:0], status: ST_OK,
                                    free_count: free_next_w[CNT_W-1:0]};
                end else if (r_wrapped && r_eval_word == start_w) begin
                    n_res = '{allocated_block: '0, status: ST_FULL,
                              free_count: free_now_w[CNT_W-1:0]};
                end else begin
                    o_mem_raddr = next_w;
                    n_eval_word = next_w;
                    n_wrapped   = r_wrapped | at_last;
                end
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cursor   <= '0;
            r_used     <= '0;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_cursor   <= n_cursor;
            r_used     <= n_used;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_idx       <= n_idx;
        r_eval_word <= n_eval_word;
        r_wrapped   <= n_wrapped;
        r_start     <= n_start;
        r_res       <= n_res;
    end

    `NFBA_ASSERT_IMP(a_write_states, i_clk, i_rst_n, o_mem_we, (r_state == S_CLEAR || r_state == S_RMW || r_state == S_SCAN), "map written outside clear, rmw or scan")
    `NFBA_ASSERT_NXT(a_alloc_count, i_clk, i_rst_n, (r_state == S_SCAN && scan_hit), (r_used == $past(r_used) + CNT_W'(1)), "allocate did not bump the used count")
    `NFBA_ASSERT_NXT(a_alloc_cursor, i_clk, i_rst_n, (r_state == S_SCAN && scan_hit), (r_res.status == ST_OK && r_res.allocated_block == r_cursor), "granted block and cursor disagree")
    `NFBA_ASSERT_NXT(a_resp_hold, i_clk, i_rst_n, (r_state == S_RESP && !i_out_ready), (r_state == S_RESP && $stable(r_res)), "pending response lost")

endmodule

`default_nettype wire

>>> rtl/next_fit_bitmap_allocator.sv
// Top level of the next-fit bitmap allocator: size register, response
// register, sequencer and map memory. Uses nfba_pkg, nfba_ctrl, nfba_map_mem.
//
//   Channel   Direction  Handshake            Payload
//   in        into       i_in_valid/o_in_stall  i_in_req   (t_in_req)
//   out       out of     o_out_valid/i_out_stall o_out_rsp (t_out_rsp)
//   cfg       into       i_cfg_valid/o_cfg_ready i_cfg_data (managed size)
//
// A free or mark request passes through accept with the map word read,
// read-modify-write, then hand-off to the response register.
// An allocate request with free blocks is accepted, then scans one map word
// (32 blocks) a cycle, since the single read port delivers one word a cycle.
// After reset the map is cleared one word per cycle, all MAX_BLOCKS/32 words
// (128 by default, at least 2), while requests are held off; size writes are
// taken at any time. A stalled response waits in the output register while
// the next request is already accepted and worked on.
`default_nettype none

module next_fit_bitmap_allocator
    import nfba_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_req          i_in_req,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_rsp              o_out_rsp,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CNT_W-1:0] i_cfg_data
);

    // Map geometry: 32 used bits per memory word.
    localparam int unsigned NWORDS    = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int unsigned MEM_DEPTH = (NWORDS > 1) ? NWORDS : 2;
    localparam int unsigned WA_W      = $clog2(MEM_DEPTH);

    logic [CNT_W-1:0]  r_size_lim;
    logic              r_out_valid;
    t_out_rsp          r_out_rsp;

    logic              rsp_valid;
    t_out_rsp          rsp;
    logic              out_ready;
    logic [WA_W-1:0]   mem_raddr, mem_waddr;
    logic [WORD_W-1:0] mem_rdata, mem_wdata;
    logic              mem_we;

    // The size register is always writable; the map, cursor and count
    // are left as they are when it changes.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_lim <= TOTAL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_size_lim <= i_cfg_data;
        end
    end

    // Response register: the sequencer hands a result over whenever the
    // register is empty or being drained in the same cycle.
    assign out_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_valid && out_ready) begin
            r_out_rsp <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // Apart from the clear pass, the sequencer writes the map only in the cycle
    // after a word is read, and the next request's read comes only after the
    // response state, so a read never sees a stale word.
    nfba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_size_lim     (r_size_lim),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_req       (i_in_req),
        .o_rsp_valid    (rsp_valid),
        .o_rsp          (rsp),
        .i_out_ready    (out_ready),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata)
    );

    nfba_map_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (WA_W)
    ) u_map_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

>>> sim/tb_next_fit_bitmap_allocator.sv
// Self-checking testbench for the next-fit bitmap allocator: a table of directed
// requests, then randomized phases at several managed sizes, scored by a predictor or hand-written responses.
// Depends on nfba_pkg and next_fit_bitmap_allocator, which needs nfba_ctrl and nfba_map_mem.
module tb_next_fit_bitmap_allocator;
    import nfba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAP_DEPTH    = MAX_BLOCKS_DEF;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int          PLAN_ROWS    = 30;

    // Opcode 3 has no function in the block and must come back as an error.
    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

    // One row of the directed plan: either a size write or a request, with a
    // hand-written response where it is obvious from the allocator's rules.
    typedef struct packed {
        logic             size_write;
        logic [CNT_W-1:0] size;
        t_in_req          req;
        logic             typed;
        t_out_rsp         want;
    } t_plan_row;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in_req          in_req    = '0;
    logic             out_stall = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CNT_W-1:0] cfg_data  = '0;
    logic             in_stall;
    logic             out_valid;
    logic             cfg_ready;
    t_out_rsp         rsp_out;

    // Predictor state: used bits, next-fit cursor, used count, size register.
    bit               block_used [MAP_DEPTH];
    logic [IDX_W-1:0] cursor_pos    = '0;
    logic [CNT_W-1:0] blocks_in_use = '0;
    logic [CNT_W-1:0] size_reg      = TOTAL_RST;

    t_out_rsp    due_responses [$];
    t_out_rsp    want_rsp;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;

    // Idling controls of the request driver and the response sink.
    bit          src_idle_on  = 1'b1;
    bit          sink_idle_on = 1'b1;
    bit          hold_go      = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned burst_left   = 0;
    bit          stall_now;

    // Directed plan. The comments track the map so that typed responses can be
    // checked by eye; untyped rows are scored by the predictor.
    t_plan_row plan [PLAN_ROWS] = '{
        // After reset every block is free and the cursor sits on block zero.
        '{1'b0, 13'd0, '{OP_ALLOC, 12'd0},     1'b1, '{12'd0, ST_OK, 13'd4095}},
        '{1'b0, 13'd0, '{OP_ALLOC, 12'd0},     1'b1, '{12'd1, ST_OK, 13'd4094}},
        '{1'b0, 13'd0, '{OP_FREE, 12'd0},      1'b1, '{12'd0, ST_OK, 13'd4095}},
        // Freeing a block that is already free is refused.
        '{1'b0, 13'd0, '{OP_FREE, 12'd0},      1'b1, '{12'd0, ST_BAD, 13'd4095}},
        '{1'b0, 13'd0, '{OP_FREE, 12'd4095},   1'b1, '{12'd0, ST_BAD, 13'd4095}},
        '{1'b0, 13'd0, '{OP_MARK, 12'd4095},   1'b1, '{12'd0, ST_OK, 13'd4094}},
        // Marking a block that is already used is refused.
        '{1'b0, 13'd0, '{OP_MARK, 12'd4095},   1'b1, '{12'd0, ST_BAD, 13'd4094}},
        '{1'b0, 13'd0, '{OP_UNUSED, 12'd4095}, 1'b1, '{12'd0, ST_BAD, 13'd4094}},
        // The index of an allocate is ignored; the scan starts at the cursor.
        '{1'b0, 13'd0, '{OP_ALLOC, 12'd4095},  1'b1, '{12'd2, ST_OK, 13'd4093}},
        '{1'b0, 13'd0, '{OP_MARK, 12'd0},      1'b1, '{12'd0, ST_OK, 13'd4092}},
        '{1'b0, 13'd0, '{OP_FREE, 12'd4095},   1'b1, '{12'd0, ST_OK, 13'd4093}},
        '{1'b0, 13'd0, '{OP_ALLOC, 12'd0},     1'b1, '{12'd3, ST_OK, 13'd4092}},
        // Shrink to four blocks, all of them used: the device is full.
        '{1'b1, 13'd4, '{OP_ALLOC, 12'd0},     1'b0, '0},
        '{1'b0, 13'd0, '{OP_ALLOC, 12'd0},     1'b1, '{12'd0, ST_FULL, 13'd0}},
        '{1'b0, 13'd0, '{OP_MARK, 12'd4},      1'b1, '{12'd0, ST_BAD, 13'd0}},
        // The next allocate wraps from the cursor past the end to block two.
        '{1'b0, 13'd0, '{OP_FREE, 12'd2},      1'b0, '0},
        '{1'b0, 13'd0, '{OP_ALLOC, 12'd0},     1'b0, '0},
        '{1'b0, 13'd0, '{OP_FREE, 12'd3},      1'b0, '0},
        '{1'b0, 13'd0, '{OP_FREE, 12'd0},      1'b0, '0},
        // Two managed blocks while blocks one and two are used: the free count
        // saturates at zero.
        '{1'b1, 13'd2, '{OP_ALLOC, 12'd0},     1'b0, '0},
        '{1'b0, 13'd0, '{OP_ALLOC, 12'd0},     1'b1, '{12'd0, ST_FULL, 13'd0}},
        '{1'b0, 13'd0, '{OP_FREE, 12'd1},      1'b0, '0},
        // The cursor now lies past the managed range, so the scan restarts at zero.
        '{1'b0, 13'd0, '{OP_ALLOC, 12'd0},     1'b0, '0},
        // With no managed blocks every allocate is full and every index is bad.
        '{1'b1, 13'd0, '{OP_ALLOC, 12'd0},     1'b0, '0},
        '{1'b0, 13'd0, '{OP_ALLOC, 12'd0},     1'b1, '{12'd0, ST_FULL, 13'd0}},
        '{1'b0, 13'd0, '{OP_FREE, 12'd0},      1'b1, '{12'd0, ST_BAD, 13'd0}},
        // An oversized register value is clamped to the map depth.
        '{1'b1, 13'd8191, '{OP_ALLOC, 12'd0},  1'b0, '0},
        '{1'b0, 13'd0, '{OP_ALLOC, 12'd0},     1'b0, '0},
        '{1'b1, 13'd1, '{OP_ALLOC, 12'd0},     1'b0, '0},
        '{1'b0, 13'd0, '{OP_FREE, 12'd0},      1'b0, '0}
    };

    next_fit_bitmap_allocator DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (rsp_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Free blocks within the managed range, saturated at zero since blocks that
    // were used before a shrink still count as used.
    function automatic int unsigned blocks_free(input int unsigned lim);
        return (lim > blocks_in_use) ? lim - blocks_in_use : 0;
    endfunction

    // Applies one request to the predictor state and returns its response.
    function automatic t_out_rsp apply_block_request(input t_in_req r);
        t_out_rsp    rsp;
        int unsigned lim;
        int unsigned pos;
        bit          hit;
        lim = (size_reg > MAP_DEPTH) ? MAP_DEPTH : size_reg;
        rsp = '0;
        rsp.status = ST_OK;
        case (r.opcode)
            OP_ALLOC: begin
                if (blocks_free(lim) == 0) begin
                    rsp.status = ST_FULL;
                end else begin
                    // Next fit: one pass from the cursor, wrapping at the size.
                    pos = (cursor_pos < lim) ? cursor_pos : 0;
                    hit = 1'b0;
                    for (int n = 0; n < lim && !hit; n++) begin
                        if (!block_used[pos]) begin
                            hit = 1'b1;
                        end else begin
                            pos = (pos + 1 >= lim) ? 0 : pos + 1;
                        end
                    end
                    if (hit) begin
                        block_used[pos] = 1'b1;
                        blocks_in_use++;
                        cursor_pos = IDX_W'(pos);
                        rsp.allocated_block = IDX_W'(pos);
                    end else begin
                        rsp.status = ST_FULL;
                    end
                end
            end
            OP_FREE: begin
                if (r.block_index >= lim || !block_used[r.block_index]) begin
                    rsp.status = ST_BAD;
                end else begin
                    block_used[r.block_index] = 1'b0;
                    if (blocks_in_use != 0) begin
                        blocks_in_use--;
                    end
                end
            end
            OP_MARK: begin
                if (r.block_index >= lim || block_used[r.block_index]) begin
                    rsp.status = ST_BAD;
                end else begin
                    block_used[r.block_index] = 1'b1;
                    blocks_in_use++;
                end
            end
            default: begin
                rsp.status = ST_BAD;
            end
        endcase
        rsp.free_count = CNT_W'(blocks_free(lim));
        return rsp;
    endfunction

    // Offers one request, with an occasional idle gap before it, and records
    // the expected response once the block takes it.
    task automatic offer_request(input t_in_req r, input bit typed, input t_out_rsp want);
        t_out_rsp got;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (in_stall);
        got = apply_block_request(r);
        due_responses.insert(due_responses.size(), typed ? want : got);
    endtask

    // The size register is only rewritten once every response is back, so the
    // block sits idle during the write.
    task automatic write_size(input logic [CNT_W-1:0] value);
        in_valid <= 1'b0;
        while (due_responses.size() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_reg = value;
    endtask

    // Random requests for one phase. Most are allocates and well-formed frees
    // of blocks known to be used; the rest are marks, stray indexes and the
    // unused opcode.
    task automatic run_phase(input int unsigned n_items);
        t_in_req     r;
        int unsigned lim;
        int unsigned pick;
        int unsigned start;
        bit          hit;
        lim = (size_reg > MAP_DEPTH) ? MAP_DEPTH : size_reg;
        for (int i = 0; i < n_items; i++) begin
            r.block_index = IDX_W'($urandom);
            r.opcode = OP_ALLOC;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                r.opcode = OP_ALLOC;
            end else if (pick < 75) begin
                r.opcode = OP_FREE;
                if (lim != 0) begin
                    start = $urandom_range(0, lim - 1);
                    hit = 1'b0;
                    for (int k = 0; k < lim && !hit; k++) begin
                        if (block_used[(start + k) % lim]) begin
                            hit = 1'b1;
                            r.block_index = IDX_W'((start + k) % lim);
                        end
                    end
                end
            end else if (pick < 88) begin
                r.opcode = OP_MARK;
                if (lim != 0) begin
                    r.block_index = IDX_W'($urandom_range(0, lim - 1));
                end
            end else if (pick < 96) begin
                r.opcode = pick[0] ? OP_FREE : OP_MARK;
            end else begin
                r.opcode = OP_UNUSED;
            end
            offer_request(r, 1'b0, '0);
        end
    endtask

    task automatic report_field(input string what, input logic [CNT_W-1:0] want,
                                input logic [CNT_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Response sink: random stall bursts, a long hold-off on request, and no
    // stalling at all when idling is switched off.
    always @(posedge clk) begin
        if (hold_go) begin
            hold_go = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (!sink_idle_on) begin
            out_stall <= 1'b0;
        end else if (burst_left != 0) begin
            burst_left--;
        end else begin
            stall_now = ($urandom_range(0, 2) == 0);
            out_stall <= stall_now;
            burst_left = stall_now ? $urandom_range(0, 11) : $urandom_range(0, 19);
        end
    end

    // Scoreboard: every accepted response is matched against the oldest
    // outstanding expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (due_responses.size() == 0) begin
                mismatches++;
                $display("%0t: response with nothing outstanding, got %h", $time, rsp_out);
            end else begin
                want_rsp = due_responses[0];
                due_responses.delete(0);
                report_field("allocated_block", CNT_W'(want_rsp.allocated_block),
                             CNT_W'(rsp_out.allocated_block));
                report_field("status", CNT_W'(want_rsp.status), CNT_W'(rsp_out.status));
                report_field("free_count", want_rsp.free_count, rsp_out.free_count);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** next_fit_bitmap_allocator: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [CNT_W-1:0] phase_size;
        int unsigned      phase_items;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Requests wait out the map-clearing pass through the input stall.
        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (plan[r].size_write) begin
                write_size(plan[r].size);
            end else begin
                offer_request(plan[r].req, plan[r].typed, plan[r].want);
            end
        end

        // Random phases, each at its own size; small sizes fill up quickly
        // and exercise the full status, large ones the long scans.
        for (int phase = 0; phase < 10; phase++) begin
            phase_items = 122;
            case (phase)
                0: phase_size = TOTAL_RST;
                1: phase_size = 13'd1;
                2: phase_size = CNT_W'($urandom_range(2, 40));
                3: phase_size = 13'd8191;
                4: phase_size = CNT_W'($urandom_range(41, 4095));
                5: begin
                    phase_size = 13'd0;
                    phase_items = 20;
                end
                6: phase_size = CNT_W'($urandom_range(4097, 8190));
                7: phase_size = CNT_W'($urandom_range(2, 64));
                8: phase_size = TOTAL_RST;
                default: phase_size = CNT_W'($urandom_range(1, 200));
            endcase
            // Phase two runs the sender flat out against a long sink hold-off
            // so the block backs up; phase four and the last two have no idling.
            src_idle_on  = !(phase == 2 || phase == 4 || phase >= 8);
            sink_idle_on = !(phase == 4 || phase >= 8);
            write_size(phase_size);
            if (phase == 2) begin
                hold_go = 1'b1;
            end
            run_phase(phase_items);
        end

        in_valid <= 1'b0;
        while (due_responses.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("** next_fit_bitmap_allocator: PASSED **");
        end else begin
            $display("** next_fit_bitmap_allocator: FAILED **");
        end
        $finish;
    end

endmodule
